FILE: design/rbes_pkg.sv
// shared types, codes and arithmetic helpers for the rigid body integrator
package rbes_pkg;

  // wide signed working format for products, sums and rounding
  localparam int WIDE = 67;
  typedef logic signed [WIDE-1:0] wide_t;

  // fixed format of damping and step duration
  localparam int UNIT_BITS = 16;
  localparam logic [16:0] UNIT_ONE = 17'd65536;

  // input beat opcodes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FORCE    = 2'd1,
    OP_FORCE_AT = 2'd2,
    OP_LOAD     = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_INV_MASS   = 3'd0,
    REG_DAMPING    = 3'd1,
    REG_GRAVITY_X  = 3'd2,
    REG_GRAVITY_Y  = 3'd3,
    REG_STEP       = 3'd4,
    REG_INV_MOMENT = 3'd5
  } cfg_reg_t;

  // datapath micro operations
  typedef enum logic [4:0] {
    DP_NOP, DP_FORCE, DP_LOAD, DP_MOVE, DP_SPIN_MUL, DP_SPIN_ADD, DP_FVEC, DP_PVEC,
    DP_SQ_X, DP_SQ_Y, DP_SQ_SUM, DP_ROOT, DP_DIV_INIT, DP_DIV_RUN, DP_DIV_WR,
    DP_FZERO, DP_VF_MUL, DP_VF_RND, DP_VG_ADD, DP_VD_MUL, DP_VD_RND, DP_D2_MUL,
    DP_D2_RND, DP_SD_MUL, DP_SD_RND, DP_CLEAR, DP_ARM, DP_T1_MUL, DP_T1_RND,
    DP_T2_MUL, DP_T2_ADD
  } dp_op_t;

  typedef struct packed {
    logic   latch;
    logic   publish;
    dp_op_t op;
    logic   axis;
  } dp_cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_zero;
    logic div_done;
  } dp_status_t;

  localparam wide_t SAT_HI = wide_t'(64'sd2147483647);
  localparam wide_t SAT_LO = -wide_t'(64'sd2147483648);

  // floor((v + 2^(k-1)) / 2^k)
  function automatic wide_t rnd_f(input wide_t v, input int unsigned k);
    wide_t half;
    half = wide_t'(1) <<< (k - 1);
    return (v + half) >>> k;
  endfunction

  // clamp to signed 32 bits, msb flags a clamp
  function automatic logic [32:0] sat_f(input wide_t v);
    logic [32:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < SAT_LO) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

FILE: design/rbes_ctrl.sv
// sequencer that steps the integrator datapath through each operation
module rbes_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rbes_pkg::dp_cmd_t      cmd,
  input  rbes_pkg::dp_status_t   status
);
  import rbes_pkg::*;

  typedef enum logic [31:0] {
    S_IDLE     = 32'h0000_0001,
    S_FORCE    = 32'h0000_0002,
    S_LOAD     = 32'h0000_0004,
    S_MOVE     = 32'h0000_0008,
    S_SPIN_MUL = 32'h0000_0010,
    S_SPIN_ADD = 32'h0000_0020,
    S_FVEC     = 32'h0000_0040,
    S_PVEC     = 32'h0000_0080,
    S_SQ_X     = 32'h0000_0100,
    S_SQ_Y     = 32'h0000_0200,
    S_SQ_SUM   = 32'h0000_0400,
    S_ROOT     = 32'h0000_0800,
    S_DIV_INIT = 32'h0000_1000,
    S_DIV_RUN  = 32'h0000_2000,
    S_DIV_WR   = 32'h0000_4000,
    S_FZERO    = 32'h0000_8000,
    S_VF_MUL   = 32'h0001_0000,
    S_VF_RND   = 32'h0002_0000,
    S_VG_ADD   = 32'h0004_0000,
    S_VD_MUL   = 32'h0008_0000,
    S_VD_RND   = 32'h0010_0000,
    S_D2_MUL   = 32'h0020_0000,
    S_D2_RND   = 32'h0040_0000,
    S_SD_MUL   = 32'h0080_0000,
    S_SD_RND   = 32'h0100_0000,
    S_CLEAR    = 32'h0200_0000,
    S_ARM      = 32'h0400_0000,
    S_T1_MUL   = 32'h0800_0000,
    S_T1_RND   = 32'h1000_0000,
    S_T2_MUL   = 32'h2000_0000,
    S_T2_ADD   = 32'h4000_0000,
    S_PUBLISH  = 32'h8000_0000
  } state_t;

  state_t state, state_next;
  logic   axis, axis_next;
  logic   tick_mode, tick_mode_next;

  assign in_stall = (state != S_IDLE);

  // next state and command
  always_comb begin
    state_next     = state;
    axis_next      = axis;
    tick_mode_next = tick_mode;
    cmd            = '0;
    cmd.op         = DP_NOP;
    cmd.axis       = axis;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch      = 1'b1;
          axis_next      = 1'b0;
          tick_mode_next = (opcode == OP_TICK);
          case (opcode)
            OP_TICK:     state_next = S_MOVE;
            OP_FORCE:    state_next = S_FORCE;
            OP_FORCE_AT: state_next = S_PVEC;
            OP_LOAD:     state_next = S_LOAD;
            default:     state_next = S_PUBLISH;
          endcase
        end
      end
      S_FORCE: begin
        cmd.op = DP_FORCE;
        state_next = S_PUBLISH;
      end
      S_LOAD: begin
        cmd.op = DP_LOAD;
        state_next = S_PUBLISH;
      end
      S_MOVE: begin
        cmd.op = DP_MOVE;
        state_next = S_SPIN_MUL;
      end
      S_SPIN_MUL: begin
        cmd.op = DP_SPIN_MUL;
        state_next = S_SPIN_ADD;
      end
      S_SPIN_ADD: begin
        cmd.op = DP_SPIN_ADD;
        axis_next = ~axis;
        state_next = axis ? S_FVEC : S_SPIN_MUL;
      end
      S_FVEC: begin
        cmd.op = DP_FVEC;
        state_next = S_SQ_X;
      end
      S_PVEC: begin
        cmd.op = DP_PVEC;
        state_next = S_SQ_X;
      end
      S_SQ_X: begin
        cmd.op = DP_SQ_X;
        state_next = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.op = DP_SQ_Y;
        state_next = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        cmd.op = DP_SQ_SUM;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = DP_ROOT;
        if (status.root_done) begin
          if (!tick_mode) begin
            state_next = S_ARM;
          end else if (status.root_zero) begin
            state_next = S_FZERO;
          end else begin
            state_next = S_DIV_INIT;
          end
        end
      end
      S_DIV_INIT: begin
        cmd.op = DP_DIV_INIT;
        state_next = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.op = DP_DIV_RUN;
        if (status.div_done) state_next = S_DIV_WR;
      end
      S_DIV_WR: begin
        cmd.op = DP_DIV_WR;
        axis_next = ~axis;
        state_next = axis ? S_VF_MUL : S_DIV_INIT;
      end
      S_FZERO: begin
        cmd.op = DP_FZERO;
        state_next = S_VF_MUL;
      end
      S_VF_MUL: begin
        cmd.op = DP_VF_MUL;
        state_next = S_VF_RND;
      end
      S_VF_RND: begin
        cmd.op = DP_VF_RND;
        state_next = S_VG_ADD;
      end
      S_VG_ADD: begin
        cmd.op = DP_VG_ADD;
        state_next = S_VD_MUL;
      end
      S_VD_MUL: begin
        cmd.op = DP_VD_MUL;
        state_next = S_VD_RND;
      end
      S_VD_RND: begin
        cmd.op = DP_VD_RND;
        axis_next = ~axis;
        state_next = axis ? S_D2_MUL : S_VF_MUL;
      end
      S_D2_MUL: begin
        cmd.op = DP_D2_MUL;
        state_next = S_D2_RND;
      end
      S_D2_RND: begin
        cmd.op = DP_D2_RND;
        state_next = S_SD_MUL;
      end
      S_SD_MUL: begin
        cmd.op = DP_SD_MUL;
        state_next = S_SD_RND;
      end
      S_SD_RND: begin
        cmd.op = DP_SD_RND;
        axis_next = ~axis;
        state_next = axis ? S_CLEAR : S_SD_MUL;
      end
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        state_next = S_PUBLISH;
      end
      S_ARM: begin
        cmd.op = DP_ARM;
        state_next = S_T1_MUL;
      end
      S_T1_MUL: begin
        cmd.op = DP_T1_MUL;
        state_next = S_T1_RND;
      end
      S_T1_RND: begin
        cmd.op = DP_T1_RND;
        state_next = S_T2_MUL;
      end
      S_T2_MUL: begin
        cmd.op = DP_T2_MUL;
        state_next = S_T2_ADD;
      end
      S_T2_ADD: begin
        cmd.op = DP_T2_ADD;
        axis_next = ~axis;
        state_next = axis ? S_PUBLISH : S_T1_MUL;
      end
      S_PUBLISH: begin
        if (!(out_valid && out_stall)) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      tick_mode <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      tick_mode <= tick_mode_next;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/rbes_datapath.sv
// body state, config registers, shared multiplier, root and divide units
module rbes_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rbes_pkg::dp_cmd_t     cmd,
  output rbes_pkg::dp_status_t  status,
  input  logic                  cfg_wr,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic signed [31:0]    first_x,
  input  logic signed [31:0]    first_y,
  input  logic signed [31:0]    second_x,
  input  logic signed [31:0]    second_y,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic signed [31:0]    vel_x,
  output logic signed [31:0]    vel_y,
  output logic signed [31:0]    moved_x,
  output logic signed [31:0]    moved_y,
  output logic signed [17:0]    facing_x,
  output logic signed [17:0]    facing_y,
  output logic signed [31:0]    spin_x,
  output logic signed [31:0]    spin_y,
  output logic                  saturated
);
  import rbes_pkg::*;

  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int DCNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [31:0] FAC_ONE = 32'd1 << FRAC_BITS;

  // config registers
  logic [31:0]        inv_mass, inv_moment;
  logic [16:0]        damp, step_dur;
  logic signed [31:0] grav [2];

  // body state and scratch
  logic signed [31:0] pos [2], vel [2], mov [2], fac [2], spin [2], frc [2], trq [2];
  logic signed [31:0] a_in [2], b_in [2];
  logic [31:0]        mag [2];
  logic               neg [2];
  logic               halved, sat;
  logic signed [65:0] prod;
  wide_t              acc;
  logic signed [31:0] t1;
  logic [16:0]        d2;
  logic [31:0]        arm;

  // root unit
  logic [63:0] rad;
  logic [31:0] root;
  logic [33:0] rem;
  logic [5:0]  rcnt;

  // divide unit
  logic [31:0]           drem;
  logic [DIV_STEPS-1:0]  dsh, quo;
  logic [DCNT_W-1:0]     dcnt;

  logic [16:0] cfg_f17;
  always_comb begin
    cfg_f17 = cfg_data[16:0];
    if (cfg_f17 > UNIT_ONE) cfg_f17 = UNIT_ONE;
  end

  // shared multiplier operand select
  logic signed [32:0] mul_a, mul_b;
  logic               mul_en;
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      DP_SPIN_MUL: begin
        mul_a = {trq[cmd.axis][31], trq[cmd.axis]};
        mul_b = {16'b0, step_dur};
      end
      DP_SQ_X: begin
        mul_a = {1'b0, mag[0]};
        mul_b = {1'b0, mag[0]};
      end
      DP_SQ_Y: begin
        mul_a = {1'b0, mag[1]};
        mul_b = {1'b0, mag[1]};
      end
      DP_VF_MUL: begin
        mul_a = {frc[cmd.axis][31], frc[cmd.axis]};
        mul_b = {1'b0, inv_mass};
      end
      DP_VF_RND: begin
        mul_a = {grav[cmd.axis][31], grav[cmd.axis]};
        mul_b = {16'b0, step_dur};
      end
      DP_VD_MUL: begin
        mul_a = {vel[cmd.axis][31], vel[cmd.axis]};
        mul_b = {16'b0, damp};
      end
      DP_D2_MUL: begin
        mul_a = {16'b0, damp};
        mul_b = {16'b0, damp};
      end
      DP_SD_MUL: begin
        mul_a = {spin[cmd.axis][31], spin[cmd.axis]};
        mul_b = {16'b0, d2};
      end
      DP_T1_MUL: begin
        mul_a = {a_in[cmd.axis][31], a_in[cmd.axis]};
        mul_b = {1'b0, arm};
      end
      DP_T2_MUL: begin
        mul_a = {t1[31], t1};
        mul_b = {1'b0, inv_moment};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // per-op arithmetic
  logic [32:0]        s_pos [2], s_mov [2], s_frc [2];
  logic signed [32:0] vec [2];
  logic [32:0]        absv [2];
  logic               big;
  wide_t              prod_w, rnd_unit, rnd_frac;
  logic [32:0]        s_spin, s_vel, s_t1, s_trq;
  wide_t              grav_term;
  logic [32:0]        arm_full;
  always_comb begin
    prod_w   = wide_t'(prod);
    rnd_unit = rnd_f(prod_w, UNIT_BITS);
    rnd_frac = rnd_f(prod_w, FRAC_BITS);
    for (int i = 0; i < 2; i++) begin
      s_pos[i] = sat_f(wide_t'(pos[i]) + wide_t'(vel[i]));
      s_mov[i] = sat_f(wide_t'(mov[i]) + wide_t'(vel[i]));
      s_frc[i] = sat_f(wide_t'(frc[i]) + wide_t'(a_in[i]));
      if (cmd.op == DP_PVEC) begin
        vec[i] = 33'(b_in[i]) - 33'(pos[i]);
      end else begin
        vec[i] = 33'(fac[i]) + 33'(spin[i]);
      end
      absv[i] = vec[i][32] ? 33'(-vec[i]) : 33'(vec[i]);
    end
    big = (absv[0][32:31] != 2'b00) || (absv[1][32:31] != 2'b00);
    s_spin = sat_f(wide_t'(spin[cmd.axis]) + rnd_unit);
    grav_term = (inv_mass != 32'd0) ? rnd_unit : wide_t'(0);
    s_vel = sat_f(wide_t'(vel[cmd.axis]) + acc + grav_term);
    s_t1  = sat_f(rnd_frac);
    s_trq = sat_f(wide_t'(trq[cmd.axis]) + rnd_frac);
    arm_full = {1'b0, root} << halved;
  end

  // root digit step
  logic [35:0] r_t, r_trial, r_diff;
  logic        r_ge;
  always_comb begin
    r_t     = {rem, rad[63:62]};
    r_trial = {2'b00, root, 2'b01};
    r_ge    = (r_t >= r_trial);
    r_diff  = r_t - r_trial;
  end

  // divide init and bit step
  logic [63:0] n_full, n_shift;
  logic [32:0] d_t, d_diff;
  logic        d_ge;
  logic [31:0] q_ext, q_cap;
  always_comb begin
    n_full  = (64'(mag[cmd.axis]) << FRAC_BITS) + 64'(root >> 1);
    n_shift = n_full >> DIV_STEPS;
    d_t     = {drem, dsh[DIV_STEPS-1]};
    d_ge    = (d_t >= {1'b0, root});
    d_diff  = d_t - {1'b0, root};
    q_ext   = 32'(quo);
    q_cap   = (q_ext > FAC_ONE) ? FAC_ONE : q_ext;
  end

  assign status.root_done = (rcnt == 6'd32);
  assign status.root_zero = (root == 32'd0);
  assign status.div_done  = (dcnt == DCNT_W'(DIV_STEPS));

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass   <= '0;
      inv_moment <= '0;
      damp       <= 17'd64881;
      step_dur   <= 17'd1092;
      grav[0]    <= '0;
      grav[1]    <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_INV_MASS:   inv_mass   <= cfg_data;
        REG_DAMPING:    damp       <= cfg_f17;
        REG_GRAVITY_X:  grav[0]    <= cfg_data;
        REG_GRAVITY_Y:  grav[1]    <= cfg_data;
        REG_STEP:       step_dur   <= cfg_f17;
        REG_INV_MOMENT: inv_moment <= cfg_data;
        default: ;
      endcase
    end
  end

  // body state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        pos[i]  <= '0;
        vel[i]  <= '0;
        mov[i]  <= '0;
        fac[i]  <= '0;
        spin[i] <= '0;
        frc[i]  <= '0;
        trq[i]  <= '0;
      end
      sat  <= 1'b0;
      rcnt <= '0;
      dcnt <= '0;
    end else begin
      if (mul_en) prod <= mul_a * mul_b;
      if (cmd.latch) begin
        a_in[0] <= first_x;
        a_in[1] <= first_y;
        b_in[0] <= second_x;
        b_in[1] <= second_y;
        sat     <= 1'b0;
      end
      case (cmd.op)
        DP_FORCE: begin
          frc[0] <= s_frc[0][31:0];
          frc[1] <= s_frc[1][31:0];
          sat    <= sat | s_frc[0][32] | s_frc[1][32];
        end
        DP_LOAD: begin
          pos[0] <= a_in[0];
          pos[1] <= a_in[1];
          vel[0] <= b_in[0];
          vel[1] <= b_in[1];
        end
        DP_MOVE: begin
          for (int i = 0; i < 2; i++) begin
            pos[i] <= s_pos[i][31:0];
            mov[i] <= s_mov[i][31:0];
          end
          sat <= sat | s_pos[0][32] | s_pos[1][32] | s_mov[0][32] | s_mov[1][32];
        end
        DP_SPIN_ADD: begin
          spin[cmd.axis] <= s_spin[31:0];
          sat <= sat | s_spin[32];
        end
        DP_FVEC, DP_PVEC: begin
          for (int i = 0; i < 2; i++) begin
            mag[i] <= big ? absv[i][32:1] : absv[i][31:0];
            neg[i] <= vec[i][32];
          end
          halved <= big;
        end
        DP_SQ_Y: rad <= prod[63:0];
        DP_SQ_SUM: begin
          rad  <= rad + prod[63:0];
          root <= '0;
          rem  <= '0;
          rcnt <= '0;
        end
        DP_ROOT: begin
          if (rcnt != 6'd32) begin
            rem  <= r_ge ? r_diff[33:0] : r_t[33:0];
            root <= {root[30:0], r_ge};
            rad  <= {rad[61:0], 2'b00};
            rcnt <= rcnt + 6'd1;
          end
        end
        DP_DIV_INIT: begin
          drem <= n_shift[31:0];
          dsh  <= n_full[DIV_STEPS-1:0];
          quo  <= '0;
          dcnt <= '0;
        end
        DP_DIV_RUN: begin
          if (dcnt != DCNT_W'(DIV_STEPS)) begin
            drem <= d_ge ? d_diff[31:0] : d_t[31:0];
            quo  <= {quo[DIV_STEPS-2:0], d_ge};
            dsh  <= {dsh[DIV_STEPS-2:0], 1'b0};
            dcnt <= dcnt + DCNT_W'(1);
          end
        end
        DP_DIV_WR: fac[cmd.axis] <= neg[cmd.axis] ? -q_cap : q_cap;
        DP_FZERO: begin
          fac[0] <= '0;
          fac[1] <= '0;
        end
        DP_VF_RND: acc <= rnd_frac;
        DP_VG_ADD: begin
          vel[cmd.axis] <= s_vel[31:0];
          sat <= sat | s_vel[32];
        end
        DP_VD_RND: vel[cmd.axis] <= rnd_unit[31:0];
        DP_D2_RND: d2 <= rnd_unit[16:0];
        DP_SD_RND: spin[cmd.axis] <= rnd_unit[31:0];
        DP_CLEAR: begin
          for (int i = 0; i < 2; i++) begin
            frc[i] <= '0;
            trq[i] <= '0;
          end
        end
        DP_ARM: begin
          arm <= arm_full[32] ? 32'hffff_ffff : arm_full[31:0];
          sat <= sat | arm_full[32];
        end
        DP_T1_RND: begin
          t1  <= s_t1[31:0];
          sat <= sat | s_t1[32];
        end
        DP_T2_ADD: begin
          trq[cmd.axis] <= s_trq[31:0];
          sat <= sat | s_trq[32];
        end
        default: ;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      pos_x     <= pos[0];
      pos_y     <= pos[1];
      vel_x     <= vel[0];
      vel_y     <= vel[1];
      moved_x   <= mov[0];
      moved_y   <= mov[1];
      facing_x  <= fac[0][17:0];
      facing_y  <= fac[1][17:0];
      spin_x    <= spin[0];
      spin_y    <= spin[1];
      saturated <= sat;
    end
  end

endmodule

FILE: design/rigid_body_euler_step.sv
// top level of the planar rigid body integrator
//
// Input channel: in_valid / in_stall with opcode and two Q vectors. A beat
// is taken when in_valid is high and in_stall low. Each beat returns one
// result beat on out_valid / out_stall carrying the body state after it.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. The user must write registers only while the block is idle;
// the block itself does not enforce this. Add force and load state update the
// body state and then publish; add force at point also runs the 32-step square
// root; tick runs the square root and, for a nonzero vector, the two bit-serial
// divides that normalise the facing vector. One beat is in flight at a time.
// All multiplies share one 33x33 multiplier.
// A finished result sits in an output register, so the next input beat is
// taken while the receiver stalls; that beat finishes and then waits for the
// register to empty. Payload holds steady while out_stall is high.
// Reset clears the body state, loads the config defaults and drops out_valid.
module rigid_body_euler_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] moved_x,
  output logic signed [31:0] moved_y,
  output logic signed [17:0] facing_x,
  output logic signed [17:0] facing_y,
  output logic signed [31:0] spin_x,
  output logic signed [31:0] spin_y,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rbes_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  rbes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic and state
  rbes_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .moved_x   (moved_x),
    .moved_y   (moved_y),
    .facing_x  (facing_x),
    .facing_y  (facing_y),
    .spin_x    (spin_x),
    .spin_y    (spin_y),
    .saturated (saturated)
  );

endmodule
